// ===== rtl/fdf_pkg.sv =====
package fdf_pkg;

   // Default ring depth
   localparam int DEPTH_DEF = 64;

   // Fixed field widths
   localparam int LEN_W     = 20;
   localparam int STAMP_W   = 33;
   localparam int HANDLE_W  = 32;
   localparam int BYTES_W   = 27;
   localparam int LIMIT_W   = 26;
   localparam int MARGIN_W  = 24;
   localparam int CSR_W     = 26;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W  = 3;

   // Register reset values
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(4194304);
   localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(1048576);

   // A get needs this many descriptors held
   localparam int MIN_HELD = 2;

   typedef enum logic {
      KIND_PUT = 1'b0,
      KIND_GET = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PUT_OK   = 3'd0,
      ST_PUT_FULL = 3'd1,
      ST_GET_OK   = 3'd2,
      ST_GET_FEW  = 3'd3,
      ST_NO_SINK  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEM_LIMIT   = 2'd0,
      CSR_WRAP_MARGIN = 2'd1
   } csr_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_READ = 1'b1
   } fsm_type;

   // One descriptor as stored in the ring memory
   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic                start;
      logic [STAMP_W-1:0]  stamp;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== rtl/frame_descriptor_fifo.sv =====
// Channel  Direction  Handshake          Payload
// req_     in         req_valid/stall    kind, frame_len, starts_frame, stamp, data_handle,
//                                        sink_ready
// rsp_     out        rsp_valid/stall    status, out_len, out_start, out_stamp, out_handle,
//                                        write_offset, urgent, frames_held
// csr_     in         csr_wr_en          csr_index, csr_wdata
//
// A put, a dropped put and a refused get load the result register directly; a delivered get
// first does the registered two-port read of the head and next descriptors from the ring
// memory, then updates the pointers and loads the result register.
// One word is worked on at a time; the next is taken once the result register is free.
// Reset clears pointers, counts and the result valid; the ring memory is not cleared.
// A stalled result holds in its register and holds off new words.
module frame_descriptor_fifo #(
   parameter int DEPTH = fdf_pkg::DEPTH_DEF,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [fdf_pkg::LEN_W-1:0]        req_frame_len,
   input  logic                             req_starts_frame,
   input  logic [fdf_pkg::STAMP_W-1:0]      req_stamp,
   input  logic [fdf_pkg::HANDLE_W-1:0]     req_data_handle,
   input  logic                             req_sink_ready,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fdf_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fdf_pkg::LEN_W-1:0]        rsp_out_len,
   output logic                             rsp_out_start,
   output logic [fdf_pkg::STAMP_W-1:0]      rsp_out_stamp,
   output logic [fdf_pkg::HANDLE_W-1:0]     rsp_out_handle,
   output logic [fdf_pkg::BYTES_W-1:0]      rsp_write_offset,
   output logic                             rsp_urgent,
   output logic [CNT_W-1:0]                 rsp_frames_held,

   input  logic                             csr_wr_en,
   input  logic [fdf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fdf_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);

   // Ring memory and its registered read ports
   fdf_pkg::entry_type mem_ram [DEPTH];
   fdf_pkg::entry_type rd_head_ff;
   fdf_pkg::entry_type rd_next_ff;

   // Control state
   fdf_pkg::fsm_type state_ff, state_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [IDX_W-1:0]            tail_ff, tail_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [fdf_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [fdf_pkg::BYTES_W-1:0] pos_ff, pos_in;
   logic [fdf_pkg::LIMIT_W-1:0]  limit_ff;
   logic [fdf_pkg::MARGIN_W-1:0] margin_ff;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   fdf_pkg::status_type          status_ff, status_in;
   fdf_pkg::entry_type           out_ff, out_in;
   logic [fdf_pkg::BYTES_W-1:0]  offset_ff;
   logic                         urgent_ff, urgent_in;
   logic [CNT_W-1:0]             held_ff;

   // Handshake and decisions
   logic                         out_free;
   logic                         accept;
   logic                         is_get;
   logic                         is_full;
   logic                         go_read;
   logic                         do_write;
   logic                         rsp_load;
   logic [IDX_W-1:0]             head_nx;
   logic [IDX_W-1:0]             tail_nx;
   logic [fdf_pkg::BYTES_W:0]    put_sum;
   logic [fdf_pkg::BYTES_W-1:0]  pos_sum;
   logic [fdf_pkg::BYTES_W-1:0]  wrap_lim;
   logic [fdf_pkg::BYTES_W-1:0]  head_len;
   fdf_pkg::entry_type           wr_entry;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= fdf_pkg::LIMIT_RST;
         margin_ff <= fdf_pkg::MARGIN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fdf_pkg::CSR_MEM_LIMIT:   limit_ff  <= csr_wdata[fdf_pkg::LIMIT_W-1:0];
            fdf_pkg::CSR_WRAP_MARGIN: margin_ff <= csr_wdata[fdf_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdf_pkg::FSM_IDLE: if (go_read) state_in = fdf_pkg::FSM_READ;
         fdf_pkg::FSM_READ: state_in = fdf_pkg::FSM_IDLE;
         default:           state_in = fdf_pkg::FSM_IDLE;
      endcase
   end

   // FSM outputs: take a word only when idle and the result register frees up
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = !((state_ff == fdf_pkg::FSM_IDLE) && out_free);
   end

   // Decisions on the accepted word
   always_comb begin
      accept   = req_valid && !req_stall;
      is_get   = (req_kind == fdf_pkg::KIND_GET);
      is_full  = (count_ff >= CNT_W'(DEPTH));
      go_read  = accept && is_get && (count_ff >= CNT_W'(fdf_pkg::MIN_HELD)) && req_sink_ready;
      do_write = accept && !is_get && !is_full;
      head_nx  = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tail_nx  = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      wr_entry.len    = req_frame_len;
      wr_entry.start  = req_starts_frame;
      wr_entry.stamp  = req_stamp;
      wr_entry.handle = req_data_handle;
   end

   // Byte total and write offset arithmetic
   always_comb begin
      put_sum  = {1'b0, bytes_ff} + (fdf_pkg::BYTES_W + 1)'(req_frame_len);
      pos_sum  = pos_ff + fdf_pkg::BYTES_W'(req_frame_len);
      wrap_lim = fdf_pkg::BYTES_W'(limit_ff) + fdf_pkg::BYTES_W'(margin_ff);
      head_len = fdf_pkg::BYTES_W'(rd_head_ff.len);
   end

   // State update and result build
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      pos_in    = pos_ff;
      rsp_load  = 1'b0;
      status_in = fdf_pkg::ST_PUT_OK;
      out_in    = '0;
      urgent_in = is_full || (bytes_ff > fdf_pkg::BYTES_W'(limit_ff));

      if (state_ff == fdf_pkg::FSM_READ) begin
         // read data back: pop the head, forward the next stamp if needed
         rsp_load  = 1'b1;
         status_in = fdf_pkg::ST_GET_OK;
         out_in    = rd_head_ff;
         if (rd_head_ff.start && !rd_next_ff.start) begin
            out_in.stamp = rd_next_ff.stamp;
         end
         head_in  = head_nx;
         count_in = count_ff - 1'b1;
         bytes_in = (bytes_ff >= head_len) ? bytes_ff - head_len : '0;
      end else if (accept) begin
         if (!is_get) begin
            rsp_load = 1'b1;
            if (is_full) begin
               status_in = fdf_pkg::ST_PUT_FULL;
            end else begin
               status_in = fdf_pkg::ST_PUT_OK;
               tail_in   = tail_nx;
               count_in  = count_ff + 1'b1;
               bytes_in  = put_sum[fdf_pkg::BYTES_W] ? '1 : put_sum[fdf_pkg::BYTES_W-1:0];
               pos_in    = (pos_sum > wrap_lim) ? '0 : pos_sum;
            end
         end else if (count_ff < CNT_W'(fdf_pkg::MIN_HELD)) begin
            rsp_load  = 1'b1;
            status_in = fdf_pkg::ST_GET_FEW;
         end else if (!req_sink_ready) begin
            rsp_load  = 1'b1;
            status_in = fdf_pkg::ST_NO_SINK;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdf_pkg::FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff <= status_in;
         out_ff    <= out_in;
         offset_ff <= pos_in;
         urgent_ff <= urgent_in;
         held_ff   <= count_in;
      end
   end

   // Ring memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ram[tail_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (go_read) begin
         rd_head_ff <= mem_ram[head_ff];
         rd_next_ff <= mem_ram[head_nx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_len      = out_ff.len;
   assign rsp_out_start    = out_ff.start;
   assign rsp_out_stamp    = out_ff.stamp;
   assign rsp_out_handle   = out_ff.handle;
   assign rsp_write_offset = offset_ff;
   assign rsp_urgent       = urgent_ff;
   assign rsp_frames_held  = held_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("descriptor count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with head and tail apart");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdf_pkg::FSM_READ) |-> !rsp_valid_ff)
      else $error("read data returned while result register busy");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fdf_pkg::FSM_READ) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("delivered get did not pop one descriptor");

   a_pop_held: assert property (@(posedge clock) disable iff (reset)
      go_read |-> (count_ff >= CNT_W'(fdf_pkg::MIN_HELD)))
      else $error("read issued with fewer than two descriptors");

endmodule
